### hdl/pngunf_pkg.sv
// ============================================================================
// PNG scanline unfilter - shared types and constants
// Item and result payloads, format, filter and register codes, and sizing
// defaults for the scanline reconstruction core.
// ============================================================================
package pngunf_pkg;

  localparam int DEF_MAX_WIDTH       = 1024;
  localparam int DEF_MAX_HEIGHT      = 4096;
  localparam int DEF_PALETTE_ENTRIES = 256;

  localparam int RESULT_FIFO_DEPTH = 8;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 13;

  localparam logic [31:0] ALPHA_OPAQUE = 32'hff000000;
  localparam logic [31:0] RGB_MASK     = 32'h00ffffff;
  localparam logic [7:0]  NIBBLE_MASK  = 8'h0f;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1,
    CFG_PIXEL_FORMAT = 2'd2,
    CFG_ALPHA_ENABLE = 2'd3
  } cfg_index_t;

  typedef enum logic [1:0] {
    FMT_PALETTE8 = 2'd0,
    FMT_RGB8     = 2'd1,
    FMT_RGBA8    = 2'd2,
    FMT_PALETTE4 = 2'd3
  } pixel_format_t;

  typedef enum logic [2:0] {
    FILT_NONE    = 3'd0,
    FILT_SUB     = 3'd1,
    FILT_UP      = 3'd2,
    FILT_AVERAGE = 3'd3,
    FILT_PAETH   = 3'd4,
    FILT_INVALID = 3'd7
  } filter_t;

  typedef struct packed {
    logic        cmd;
    logic [7:0]  data_byte;
    logic [7:0]  palette_index;
    logic [23:0] palette_rgb;
    logic [7:0]  palette_alpha;
  } item_t;

  typedef struct packed {
    logic [31:0] pixel_rgba;
    logic [9:0]  pixel_x;
    logic [11:0] pixel_row;
    logic        bad_filter;
    logic        last_of_image;
    logic        last_of_item;
  } result_t;

endpackage

### hdl/png_scanline_unfilter_core.sv
// ============================================================================
// PNG scanline unfilter core
// Undoes PNG row filters on an inflated byte stream and emits RGBA pixels.
// ============================================================================
// Channels: item (valid/stall) carries one stream byte or one palette write;
// result (valid/stall) carries one pixel or one bad-filter report; cfg
// (valid/ready, always ready) writes width, height, format and alpha enable;
// the user must write them only while no item is in flight; the core leaves this unenforced.
// Each row opens with its filter-type byte. Bytes run through a three-stage
// pipe: line store read, reconstruction and palette read, result push.
// Items are taken one per cycle while item_stall is low; 4-bit palette bytes
// give up to two results each, so the result port limits their rate.
// The line store gives one read and one write per cycle; the palette gives
// two reads and one write.
// Reset clears the row position, row counter and pipe; line store and
// palette contents stay undefined until written and need no clearing pass.
// When the receiver stalls, results collect in an eight-entry queue;
// item_stall rises once the queue cannot hold two results for every item
// still in the pipe plus the next one.
// ============================================================================
module png_scanline_unfilter_core #(
  parameter int MAX_WIDTH       = pngunf_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT      = pngunf_pkg::DEF_MAX_HEIGHT,
  parameter int PALETTE_ENTRIES = pngunf_pkg::DEF_PALETTE_ENTRIES
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  output logic                              item_stall,
  input  pngunf_pkg::item_t                 item,
  output logic                              result_valid,
  input  logic                              result_stall,
  output pngunf_pkg::result_t               result,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  pngunf_pkg::cfg_index_t            cfg_index,
  input  logic [pngunf_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int LINE_DEPTH = 4 * MAX_WIDTH;
  localparam int LA_W       = $clog2(LINE_DEPTH);
  localparam int POS_W      = $clog2(LINE_DEPTH + 1);
  localparam int WID_W      = $clog2(MAX_WIDTH + 1);
  localparam int HGT_W      = $clog2(MAX_HEIGHT + 1);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int XW         = LA_W + 1;
  localparam int DIV_S      = LA_W + 1;
  localparam int DIV_M      = (2 ** DIV_S + 2) / 3;
  localparam int PROD_W     = LA_W + DIV_S;
  localparam int PAL_AW     = $clog2(PALETTE_ENTRIES);
  localparam int CW         = $clog2(pngunf_pkg::RESULT_FIFO_DEPTH + 1);
  localparam int RW         = CW + 2;

  typedef enum logic [2:0] {
    OP_START,
    OP_ERROR,
    OP_RAW,
    OP_NIBBLE,
    OP_BYTE
  } op_t;

  typedef enum logic [1:0] {
    RES_ERROR,
    RES_DIRECT,
    RES_PALETTE,
    RES_NIBBLE
  } res_kind_t;

  typedef struct packed {
    op_t                       op;
    logic [7:0]                db;
    logic [LA_W-1:0]           addr;
    logic                      first_row;
    pngunf_pkg::filter_t       filter;
    pngunf_pkg::pixel_format_t fmt;
    logic [1:0]                k;
    logic                      kfinal;
    logic [XW-1:0]             x;
    logic [ROW_W-1:0]          row;
    logic                      last_a;
    logic                      last_b;
    logic                      second;
  } s1_t;

  typedef struct packed {
    res_kind_t        kind;
    logic [31:0]      rgba;
    logic [XW-1:0]    x;
    logic [ROW_W-1:0] row;
    logic             last_a;
    logic             last_b;
    logic             second;
    logic             ok_a;
    logic             ok_b;
  } s2_t;

  // configuration
  logic [10:0]               image_width;
  logic [12:0]               image_height;
  pngunf_pkg::pixel_format_t pixel_format;
  logic                      alpha_table_enable;

  // row control
  logic [POS_W-1:0]    byte_position;
  logic [ROW_W-1:0]    row_counter;
  pngunf_pkg::filter_t row_filter;
  logic                row_bad;

  // reconstruction state
  logic [31:0] left_bytes;
  logic [31:0] upper_left_bytes;
  logic [31:0] pixel_assembly;

  // pipe
  logic s1_valid;
  s1_t  s1;
  logic s2_valid;
  s2_t  s2;

  // stage 0 signals
  logic                      accept;
  logic                      data_accept;
  logic                      pal_write;
  logic [WID_W-1:0]          w_eff;
  logic [HGT_W-1:0]          h_eff;
  logic [POS_W-1:0]          rowlen;
  logic                      row_wrap;
  logic [ROW_W-1:0]          rc_eff;
  logic [HGT_W-1:0]          rc_inc;
  logic [ROW_W-1:0]          row_after;
  logic                      last_row;
  logic                      end_of_row;
  logic [LA_W-1:0]           i_idx;
  logic [PROD_W-1:0]         prod;
  logic [LA_W-1:0]           q3;
  logic [LA_W-1:0]           rem3;
  logic [XW-1:0]             x_sel;
  logic [XW-1:0]             x_sel1;
  logic [XW-1:0]             w_x;
  logic [1:0]                k_sel;
  logic                      kfinal_sel;
  logic                      filt_bad;
  logic                      row_bad_new;
  pngunf_pkg::filter_t       row_filter_new;

  // stage 1 signals
  logic [7:0]  ls_rdata;
  logic [7:0]  above;
  logic [7:0]  left;
  logic [7:0]  upleft;
  logic [8:0]  avg_sum;
  logic [7:0]  val;
  logic [31:0] asm_next;
  logic        ls_we;
  logic [7:0]  ls_wdata;
  logic [7:0]  pal_idx_a;
  logic [7:0]  pal_idx_b;

  // stage 2 signals
  logic [31:0]         pal_rdata_a;
  logic [31:0]         pal_rdata_b;
  logic [31:0]         colour_a;
  logic [31:0]         colour_b;
  logic [31:0]         x_ext0;
  logic [31:0]         x_ext1;
  logic [31:0]         row_ext;
  logic [1:0]          push_n;
  pngunf_pkg::result_t res_a;
  pngunf_pkg::result_t res_b;

  logic          fifo_pop;
  logic [CW-1:0] fifo_count;

  function automatic logic [7:0] paeth_predict(input logic [7:0] a, input logic [7:0] b,
                                               input logic [7:0] c);
    logic signed [10:0] sa;
    logic signed [10:0] sb;
    logic signed [10:0] sc;
    logic signed [10:0] p;
    logic signed [10:0] pa;
    logic signed [10:0] pb;
    logic signed [10:0] pc;
    sa = 11'(a);
    sb = 11'(b);
    sc = 11'(c);
    p  = sa + sb - sc;
    pa = p - sa;
    pb = p - sb;
    pc = p - sc;
    if (pa < 0) pa = -pa;
    if (pb < 0) pb = -pb;
    if (pc < 0) pc = -pc;
    if ((pa <= pb) && (pa <= pc)) begin
      paeth_predict = a;
    end else if (pb <= pc) begin
      paeth_predict = b;
    end else begin
      paeth_predict = c;
    end
  endfunction

  // --------------------------------------------------------------------------
  // configuration port
  // --------------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width        <= 11'd1;
      image_height       <= 13'd1;
      pixel_format       <= pngunf_pkg::FMT_PALETTE8;
      alpha_table_enable <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pngunf_pkg::CFG_IMAGE_WIDTH:  image_width  <= cfg_data[10:0];
        pngunf_pkg::CFG_IMAGE_HEIGHT: image_height <= cfg_data[12:0];
        pngunf_pkg::CFG_PIXEL_FORMAT:
          pixel_format <= pngunf_pkg::pixel_format_t'(cfg_data[1:0]);
        pngunf_pkg::CFG_ALPHA_ENABLE: alpha_table_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // stage 0: accept, row position, line store read
  // --------------------------------------------------------------------------
  assign item_stall = (RW'(fifo_count) + (s1_valid ? RW'(2) : RW'(0)) +
                       (s2_valid ? RW'(2) : RW'(0)) + RW'(2)) >
                      RW'(pngunf_pkg::RESULT_FIFO_DEPTH);

  assign accept      = item_valid && !item_stall;
  assign data_accept = accept && !item.cmd;
  assign pal_write   = accept && item.cmd && (32'(item.palette_index) < PALETTE_ENTRIES);

  always_comb begin
    if (image_width == '0) begin
      w_eff = WID_W'(1);
    end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
      w_eff = WID_W'(MAX_WIDTH);
    end else begin
      w_eff = WID_W'(image_width);
    end
    if (image_height == '0) begin
      h_eff = HGT_W'(1);
    end else if (32'(image_height) > 32'(MAX_HEIGHT)) begin
      h_eff = HGT_W'(MAX_HEIGHT);
    end else begin
      h_eff = HGT_W'(image_height);
    end
  end

  always_comb begin
    logic [WID_W:0] w_plus;
    w_plus = {1'b0, w_eff} + (WID_W + 1)'(1);
    case (pixel_format)
      pngunf_pkg::FMT_RGB8:     rowlen = POS_W'({w_eff, 1'b0}) + POS_W'(w_eff);
      pngunf_pkg::FMT_RGBA8:    rowlen = POS_W'({w_eff, 2'b00});
      pngunf_pkg::FMT_PALETTE4: rowlen = POS_W'(w_plus[WID_W:1]);
      default:                  rowlen = POS_W'(w_eff);
    endcase
  end

  assign row_wrap   = HGT_W'(row_counter) >= h_eff;
  assign rc_eff     = row_wrap ? '0 : row_counter;
  assign rc_inc     = HGT_W'(rc_eff) + HGT_W'(1);
  assign row_after  = (rc_inc >= h_eff) ? '0 : rc_inc[ROW_W-1:0];
  assign last_row   = HGT_W'(rc_eff) == (h_eff - HGT_W'(1));
  assign end_of_row = byte_position >= rowlen;

  assign i_idx = LA_W'(byte_position - POS_W'(1));
  assign prod  = PROD_W'(i_idx) * PROD_W'(DIV_M);
  assign q3    = prod[PROD_W-1:DIV_S];
  assign rem3  = i_idx - ((q3 << 1) + q3);

  always_comb begin
    case (pixel_format)
      pngunf_pkg::FMT_RGB8: begin
        x_sel      = XW'(q3);
        k_sel      = rem3[1:0];
        kfinal_sel = (rem3[1:0] == 2'd2);
      end
      pngunf_pkg::FMT_RGBA8: begin
        x_sel      = XW'(i_idx >> 2);
        k_sel      = i_idx[1:0];
        kfinal_sel = (i_idx[1:0] == 2'd3);
      end
      pngunf_pkg::FMT_PALETTE4: begin
        x_sel      = {i_idx, 1'b0};
        k_sel      = 2'd0;
        kfinal_sel = 1'b1;
      end
      default: begin
        x_sel      = XW'(i_idx);
        k_sel      = 2'd0;
        kfinal_sel = 1'b1;
      end
    endcase
  end

  assign w_x    = XW'(w_eff);
  assign x_sel1 = x_sel + XW'(1);

  assign filt_bad       = item.data_byte > 8'(pngunf_pkg::FILT_PAETH);
  assign row_bad_new    = filt_bad || ((pixel_format == pngunf_pkg::FMT_PALETTE4) &&
                                       (item.data_byte != 8'(pngunf_pkg::FILT_NONE)));
  assign row_filter_new = filt_bad ? pngunf_pkg::FILT_INVALID :
                                     pngunf_pkg::filter_t'(item.data_byte[2:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      row_counter   <= '0;
      row_filter    <= pngunf_pkg::FILT_NONE;
      row_bad       <= 1'b0;
    end else if (data_accept) begin
      if (byte_position == '0) begin
        row_filter    <= row_filter_new;
        row_bad       <= row_bad_new;
        byte_position <= POS_W'(1);
        row_counter   <= rc_eff;
      end else if (end_of_row) begin
        byte_position <= '0;
        row_counter   <= row_after;
      end else begin
        byte_position <= byte_position + POS_W'(1);
        row_counter   <= rc_eff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= data_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (data_accept) begin
      if (byte_position == '0) begin
        s1.op <= row_bad_new ? OP_ERROR : OP_START;
      end else if (row_bad) begin
        s1.op <= OP_RAW;
      end else if (pixel_format == pngunf_pkg::FMT_PALETTE4) begin
        s1.op <= OP_NIBBLE;
      end else begin
        s1.op <= OP_BYTE;
      end
      s1.db        <= item.data_byte;
      s1.addr      <= i_idx;
      s1.first_row <= (rc_eff == '0);
      s1.filter    <= row_filter;
      s1.fmt       <= pixel_format;
      s1.k         <= k_sel;
      s1.kfinal    <= kfinal_sel;
      s1.x         <= x_sel;
      s1.row       <= rc_eff;
      s1.last_a    <= last_row && (x_sel == (w_x - XW'(1)));
      s1.last_b    <= last_row && (x_sel1 == (w_x - XW'(1)));
      s1.second    <= x_sel1 < w_x;
    end
  end

  pngunf_line_store #(
    .DEPTH (LINE_DEPTH)
  ) u_line_store (
    .clk   (clk),
    .we    (ls_we),
    .waddr (s1.addr),
    .wdata (ls_wdata),
    .re    (data_accept),
    .raddr (i_idx),
    .rdata (ls_rdata)
  );

  // --------------------------------------------------------------------------
  // stage 1: reconstruct byte, write back, palette read
  // --------------------------------------------------------------------------
  assign above = s1.first_row ? 8'd0 : ls_rdata;

  always_comb begin
    case (s1.fmt)
      pngunf_pkg::FMT_RGB8: begin
        left   = left_bytes[23:16];
        upleft = upper_left_bytes[23:16];
      end
      pngunf_pkg::FMT_RGBA8: begin
        left   = left_bytes[31:24];
        upleft = upper_left_bytes[31:24];
      end
      default: begin
        left   = left_bytes[7:0];
        upleft = upper_left_bytes[7:0];
      end
    endcase
  end

  assign avg_sum = {1'b0, left} + {1'b0, above};

  always_comb begin
    case (s1.filter)
      pngunf_pkg::FILT_SUB:     val = s1.db + left;
      pngunf_pkg::FILT_UP:      val = s1.db + above;
      pngunf_pkg::FILT_AVERAGE: val = s1.db + avg_sum[8:1];
      pngunf_pkg::FILT_PAETH:   val = s1.db + paeth_predict(left, above, upleft);
      default:                  val = s1.db;
    endcase
  end

  always_comb begin
    case (s1.k)
      2'd0:    asm_next = {24'd0, val};
      2'd1:    asm_next = pixel_assembly | {16'd0, val, 8'd0};
      2'd2:    asm_next = pixel_assembly | {8'd0, val, 16'd0};
      default: asm_next = pixel_assembly | {val, 24'd0};
    endcase
  end

  assign ls_we    = s1_valid && ((s1.op == OP_RAW) || (s1.op == OP_NIBBLE) ||
                                 (s1.op == OP_BYTE));
  assign ls_wdata = (s1.op == OP_BYTE) ? val : s1.db;

  always_ff @(posedge clk) begin
    if (rst) begin
      left_bytes       <= '0;
      upper_left_bytes <= '0;
      pixel_assembly   <= '0;
    end else if (s1_valid) begin
      if ((s1.op == OP_START) || (s1.op == OP_ERROR)) begin
        left_bytes       <= '0;
        upper_left_bytes <= '0;
        pixel_assembly   <= '0;
      end else if (s1.op == OP_BYTE) begin
        left_bytes       <= {left_bytes[23:0], val};
        upper_left_bytes <= {upper_left_bytes[23:0], above};
        pixel_assembly   <= asm_next;
      end
    end
  end

  assign pal_idx_a = (s1.op == OP_NIBBLE) ? (s1.db >> 4) : val;
  assign pal_idx_b = s1.db & pngunf_pkg::NIBBLE_MASK;

  pngunf_palette #(
    .ENTRIES (PALETTE_ENTRIES)
  ) u_palette (
    .clk     (clk),
    .we      (pal_write),
    .waddr   (PAL_AW'(item.palette_index)),
    .wdata   ({item.palette_alpha, item.palette_rgb}),
    .raddr_a (PAL_AW'(pal_idx_a)),
    .raddr_b (PAL_AW'(pal_idx_b)),
    .rdata_a (pal_rdata_a),
    .rdata_b (pal_rdata_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid && ((s1.op == OP_ERROR) || (s1.op == OP_NIBBLE) ||
                               ((s1.op == OP_BYTE) && s1.kfinal));
    end
  end

  always_ff @(posedge clk) begin
    if (s1.op == OP_ERROR) begin
      s2.kind <= RES_ERROR;
    end else if (s1.op == OP_NIBBLE) begin
      s2.kind <= RES_NIBBLE;
    end else if (s1.fmt == pngunf_pkg::FMT_PALETTE8) begin
      s2.kind <= RES_PALETTE;
    end else begin
      s2.kind <= RES_DIRECT;
    end
    s2.rgba   <= (s1.fmt == pngunf_pkg::FMT_RGB8) ?
                 ((asm_next & pngunf_pkg::RGB_MASK) | pngunf_pkg::ALPHA_OPAQUE) : asm_next;
    s2.x      <= s1.x;
    s2.row    <= s1.row;
    s2.last_a <= s1.last_a;
    s2.last_b <= s1.last_b;
    s2.second <= s1.second;
    s2.ok_a   <= 32'(pal_idx_a) < PALETTE_ENTRIES;
    s2.ok_b   <= 32'(pal_idx_b) < PALETTE_ENTRIES;
  end

  // --------------------------------------------------------------------------
  // stage 2: palette colour, result push
  // --------------------------------------------------------------------------
  always_comb begin
    colour_a = s2.ok_a ? pal_rdata_a : 32'd0;
    colour_b = s2.ok_b ? pal_rdata_b : 32'd0;
    if (!alpha_table_enable) begin
      colour_a = (colour_a & pngunf_pkg::RGB_MASK) | pngunf_pkg::ALPHA_OPAQUE;
      colour_b = (colour_b & pngunf_pkg::RGB_MASK) | pngunf_pkg::ALPHA_OPAQUE;
    end
  end

  assign x_ext0  = 32'(s2.x);
  assign x_ext1  = 32'(s2.x + XW'(1));
  assign row_ext = 32'(s2.row);

  always_comb begin
    res_a.pixel_rgba    = s2.rgba;
    res_a.pixel_x       = x_ext0[9:0];
    res_a.pixel_row     = row_ext[11:0];
    res_a.bad_filter    = 1'b0;
    res_a.last_of_image = s2.last_a;
    res_a.last_of_item  = 1'b1;
    res_b.pixel_rgba    = colour_b;
    res_b.pixel_x       = x_ext1[9:0];
    res_b.pixel_row     = row_ext[11:0];
    res_b.bad_filter    = 1'b0;
    res_b.last_of_image = s2.last_b;
    res_b.last_of_item  = 1'b1;
    push_n              = s2_valid ? 2'd1 : 2'd0;
    case (s2.kind)
      RES_ERROR: begin
        res_a.pixel_rgba    = 32'd0;
        res_a.pixel_x       = 10'd0;
        res_a.bad_filter    = 1'b1;
        res_a.last_of_image = 1'b0;
      end
      RES_PALETTE: begin
        res_a.pixel_rgba = colour_a;
      end
      RES_NIBBLE: begin
        res_a.pixel_rgba   = colour_a;
        res_a.last_of_item = !s2.second;
        if (s2_valid && s2.second) begin
          push_n = 2'd2;
        end
      end
      default: ;
    endcase
  end

  assign fifo_pop = result_valid && !result_stall;

  pngunf_result_fifo #(
    .DEPTH (pngunf_pkg::RESULT_FIFO_DEPTH)
  ) u_result_fifo (
    .clk    (clk),
    .rst    (rst),
    .push_n (push_n),
    .push_a (res_a),
    .push_b (res_b),
    .pop    (fifo_pop),
    .head   (result),
    .avail  (result_valid),
    .count  (fifo_count)
  );

endmodule

### hdl/pngunf_line_store.sv
// ============================================================================
// PNG scanline unfilter - line store
// Single-port-write, single-port-read byte memory holding the previous row,
// with a registered read; new data returned on a same-address collision.
// ============================================================================
module pngunf_line_store #(
  parameter int DEPTH = 4 * pngunf_pkg::DEF_MAX_WIDTH
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [7:0]               wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [7:0]               rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= (we && (waddr == raddr)) ? wdata : mem[raddr];
    end
  end

endmodule

### hdl/pngunf_palette.sv
// ============================================================================
// PNG scanline unfilter - palette store
// RGBA palette memory with one write port and two registered read ports.
// ============================================================================
module pngunf_palette #(
  parameter int ENTRIES = pngunf_pkg::DEF_PALETTE_ENTRIES
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(ENTRIES)-1:0] waddr,
  input  logic [31:0]                wdata,
  input  logic [$clog2(ENTRIES)-1:0] raddr_a,
  input  logic [$clog2(ENTRIES)-1:0] raddr_b,
  output logic [31:0]                rdata_a,
  output logic [31:0]                rdata_b
);

  logic [31:0] mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

### hdl/pngunf_result_fifo.sv
// ============================================================================
// PNG scanline unfilter - result queue
// Small result FIFO taking up to two results per cycle and giving one.
// ============================================================================
module pngunf_result_fifo #(
  parameter int DEPTH = pngunf_pkg::RESULT_FIFO_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [1:0]                 push_n,
  input  pngunf_pkg::result_t        push_a,
  input  pngunf_pkg::result_t        push_b,
  input  logic                       pop,
  output pngunf_pkg::result_t        head,
  output logic                       avail,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;

  pngunf_pkg::result_t mem [DEPTH];

  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW-1:0] wr_ptr1;
  logic [PW-1:0] wr_ptr2;
  logic [PW-1:0] rd_ptr1;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign wr_ptr1 = ptr_inc(wr_ptr);
  assign wr_ptr2 = ptr_inc(wr_ptr1);
  assign rd_ptr1 = ptr_inc(rd_ptr);
  assign head    = mem[rd_ptr];
  assign avail   = (count != '0);

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem[wr_ptr] <= push_a;
    end
    if (push_n == 2'd2) begin
      mem[wr_ptr1] <= push_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      case (push_n)
        2'd1:    wr_ptr <= wr_ptr1;
        2'd2:    wr_ptr <= wr_ptr2;
        default: wr_ptr <= wr_ptr;
      endcase
      if (pop) begin
        rd_ptr <= rd_ptr1;
      end
      count <= count + CW'(push_n) - CW'(pop);
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (SW'(count) + SW'(push_n)) <= SW'(DEPTH))
    else $error("result queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> (count != '0))
    else $error("result queue underflow");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> (wr_ptr == rd_ptr))
    else $error("result queue pointers disagree with count");
`endif

endmodule

### sim/tb_png_scanline_unfilter_core.sv
// ============================================================================
// PNG scanline unfilter core - self-checking testbench
// Drives palette writes and filtered scanline bytes into the core under several
// width, height, format and alpha settings. A behavioural copy of the unfilter
// predicts every pixel and bad-filter report. A monitor compares each
// transfer on the result channel with the oldest prediction. Idle bursts are
// applied on both channels.
// ============================================================================
module tb_png_scanline_unfilter_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_PAUSE = 6;
  localparam int QUIET_LIMIT = 2000;
  localparam int LINE_DEPTH  = 4 * pngunf_pkg::DEF_MAX_WIDTH;

  logic                              clk;
  logic                              rst          = 1'b1;
  logic                              item_valid   = 1'b0;
  logic                              item_stall;
  pngunf_pkg::item_t                 item         = '0;
  logic                              result_valid;
  logic                              result_stall = 1'b0;
  pngunf_pkg::result_t               result;
  logic                              cfg_valid    = 1'b0;
  logic                              cfg_ready;
  pngunf_pkg::cfg_index_t            cfg_index    = pngunf_pkg::CFG_IMAGE_WIDTH;
  logic [pngunf_pkg::CFG_DATA_W-1:0] cfg_data     = '0;

  png_scanline_unfilter_core DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Stimulus and flow control
  pngunf_pkg::item_t pending_items[$];
  int unsigned       items_queued  = 0;
  int unsigned       items_taken   = 0;
  logic              item_fire     = 1'b0;
  int                gap_pct       = 15;
  int                stall_pct     = 15;
  int                gap_left      = 0;
  int                stall_left    = 0;

  // Unfilter state and settings as seen by the predictor
  logic [10:0]               reg_width;
  logic [12:0]               reg_height;
  pngunf_pkg::pixel_format_t reg_format;
  logic                      reg_alpha;
  logic [7:0]                line_mem [0:LINE_DEPTH-1];
  logic [31:0]               pal_mem [0:255];
  logic [31:0]               left_q, ul_q, pix_acc;
  int                        byte_pos, row_num;
  pngunf_pkg::filter_t       row_filt;
  logic                      row_is_bad;

  pngunf_pkg::result_t expected_pixels[$];
  pngunf_pkg::result_t want_pixel;
  int unsigned         mismatches   = 0;
  int                  quiet_cycles = 0;

  function automatic int bytes_per_px(pngunf_pkg::pixel_format_t f);
    case (f)
      pngunf_pkg::FMT_RGB8:  return 3;
      pngunf_pkg::FMT_RGBA8: return 4;
      default:               return 1;
    endcase
  endfunction

  function automatic int row_bytes(pngunf_pkg::pixel_format_t f, int w);
    if (f == pngunf_pkg::FMT_PALETTE4) return (w + 1) / 2;
    return w * bytes_per_px(f);
  endfunction

  function automatic logic [31:0] pal_colour(logic [7:0] idx);
    logic [31:0] e;
    e = (int'(idx) < pngunf_pkg::DEF_PALETTE_ENTRIES) ? pal_mem[idx] : 32'h0;
    return reg_alpha ? e : ((e & pngunf_pkg::RGB_MASK) | pngunf_pkg::ALPHA_OPAQUE);
  endfunction

  function automatic logic [7:0] paeth_pick(logic [7:0] a, logic [7:0] b, logic [7:0] c);
    int p, pa, pb, pc;
    p  = int'(a) + int'(b) - int'(c);
    pa = (p >= int'(a)) ? p - int'(a) : int'(a) - p;
    pb = (p >= int'(b)) ? p - int'(b) : int'(b) - p;
    pc = (p >= int'(c)) ? p - int'(c) : int'(c) - p;
    if (pa <= pb && pa <= pc) return a;
    if (pb <= pc) return b;
    return c;
  endfunction

  function automatic pngunf_pkg::result_t pixel_word(logic [31:0] rgba, int x, int row,
                                                     logic bad, logic last_img);
    pngunf_pkg::result_t r;
    r.pixel_rgba    = rgba;
    r.pixel_x       = 10'(x);
    r.pixel_row     = 12'(row);
    r.bad_filter    = bad;
    r.last_of_image = last_img;
    r.last_of_item  = 1'b0;
    return r;
  endfunction

  task automatic unfilter_item(pngunf_pkg::item_t it);
    int                  w, h, len, i, bpp, k, x, avg;
    logic [7:0]          db, up, lf, ul, v;
    logic [31:0]         rgba;
    logic                last_row;
    pngunf_pkg::result_t made[$];
    if (it.cmd) begin
      if (int'(it.palette_index) < pngunf_pkg::DEF_PALETTE_ENTRIES)
        pal_mem[it.palette_index] = {it.palette_alpha, it.palette_rgb};
      return;
    end
    db = it.data_byte;
    w  = int'(reg_width);
    h  = int'(reg_height);
    if (w == 0) w = 1;
    if (w > pngunf_pkg::DEF_MAX_WIDTH) w = pngunf_pkg::DEF_MAX_WIDTH;
    if (h == 0) h = 1;
    if (h > pngunf_pkg::DEF_MAX_HEIGHT) h = pngunf_pkg::DEF_MAX_HEIGHT;
    if (row_num >= h) row_num = 0;
    if (byte_pos == 0) begin
      row_filt   = (db > 8'(pngunf_pkg::FILT_PAETH)) ? pngunf_pkg::FILT_INVALID :
                                                       pngunf_pkg::filter_t'(db[2:0]);
      row_is_bad = (db > 8'(pngunf_pkg::FILT_PAETH)) ||
                   (reg_format == pngunf_pkg::FMT_PALETTE4 &&
                    db != 8'(pngunf_pkg::FILT_NONE));
      left_q   = '0;
      ul_q     = '0;
      pix_acc  = '0;
      byte_pos = 1;
      if (row_is_bad) made.push_back(pixel_word(32'h0, 0, row_num, 1'b1, 1'b0));
    end else begin
      len = row_bytes(reg_format, w);
      i   = byte_pos - 1;
      if (i >= LINE_DEPTH) i = LINE_DEPTH - 1;
      bpp = bytes_per_px(reg_format);
      last_row = (row_num == h - 1);
      if (row_is_bad) begin
        line_mem[i] = db;
      end else if (reg_format == pngunf_pkg::FMT_PALETTE4) begin
        x = 2 * i;
        line_mem[i] = db;
        made.push_back(pixel_word(pal_colour({4'h0, db[7:4]}), x, row_num, 1'b0,
                                  last_row && x == w - 1));
        if (x + 1 < w)
          made.push_back(pixel_word(pal_colour(db & pngunf_pkg::NIBBLE_MASK), x + 1,
                                    row_num, 1'b0, last_row && x + 1 == w - 1));
      end else begin
        k  = i % bpp;
        x  = i / bpp;
        up = (row_num == 0) ? 8'h00 : line_mem[i];
        lf = 8'(left_q >> (8 * (bpp - 1)));
        ul = 8'(ul_q >> (8 * (bpp - 1)));
        case (row_filt)
          pngunf_pkg::FILT_SUB:     v = db + lf;
          pngunf_pkg::FILT_UP:      v = db + up;
          pngunf_pkg::FILT_AVERAGE: begin
            avg = (int'(lf) + int'(up)) >> 1;
            v   = db + avg[7:0];
          end
          pngunf_pkg::FILT_PAETH:   v = db + paeth_pick(lf, up, ul);
          default:                  v = db;
        endcase
        line_mem[i] = v;
        left_q = {left_q[23:0], v};
        ul_q   = {ul_q[23:0], up};
        if (k == 0) pix_acc = {24'h0, v};
        else        pix_acc = pix_acc | ({24'h0, v} << (8 * k));
        if (k == bpp - 1) begin
          case (reg_format)
            pngunf_pkg::FMT_PALETTE8: rgba = pal_colour(v);
            pngunf_pkg::FMT_RGB8:
              rgba = (pix_acc & pngunf_pkg::RGB_MASK) | pngunf_pkg::ALPHA_OPAQUE;
            default:                  rgba = pix_acc;
          endcase
          made.push_back(pixel_word(rgba, x, row_num, 1'b0, last_row && x == w - 1));
        end
      end
      if (i + 1 >= len) begin
        byte_pos = 0;
        row_num  = (row_num + 1 >= h) ? 0 : row_num + 1;
      end else begin
        byte_pos++;
      end
    end
    foreach (made[n]) begin
      made[n].last_of_item = (n == made.size() - 1);
      expected_pixels.push_back(made[n]);
    end
  endtask

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(negedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!item_valid || item_fire) begin
      if (gap_left > 0) begin
        gap_left--;
        item_valid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        item       <= pending_items.pop_front();
        item_valid <= 1'b1;
        if ($urandom_range(1, 100) <= gap_pct) gap_left = $urandom_range(1, 12);
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      result_stall <= 1'b1;
    end else begin
      result_stall <= 1'b0;
      if ($urandom_range(1, 100) <= stall_pct) stall_left = $urandom_range(1, 12);
    end
  end

  always @(posedge clk) begin
    item_fire <= item_valid && !item_stall && !rst;
    if (rst) begin
      reg_width    = 11'd1;
      reg_height   = 13'd1;
      reg_format   = pngunf_pkg::FMT_PALETTE8;
      reg_alpha    = 1'b0;
      left_q       = '0;
      ul_q         = '0;
      pix_acc      = '0;
      byte_pos     = 0;
      row_num      = 0;
      row_filt     = pngunf_pkg::FILT_NONE;
      row_is_bad   = 1'b0;
      quiet_cycles = 0;
    end else begin
      if (result_valid && !result_stall) begin
        if (expected_pixels.size() == 0) begin
          $error("result transfer with nothing pending: %h", result);
          mismatches++;
        end else begin
          want_pixel = expected_pixels.pop_front();
          compare_field("pixel_rgba", want_pixel.pixel_rgba, result.pixel_rgba);
          compare_field("pixel_x", 32'(want_pixel.pixel_x), 32'(result.pixel_x));
          compare_field("pixel_row", 32'(want_pixel.pixel_row), 32'(result.pixel_row));
          compare_field("bad_filter", 32'(want_pixel.bad_filter), 32'(result.bad_filter));
          compare_field("last_of_image", 32'(want_pixel.last_of_image),
                        32'(result.last_of_image));
          compare_field("last_of_item", 32'(want_pixel.last_of_item),
                        32'(result.last_of_item));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          pngunf_pkg::CFG_IMAGE_WIDTH:  reg_width  = cfg_data[10:0];
          pngunf_pkg::CFG_IMAGE_HEIGHT: reg_height = cfg_data[12:0];
          pngunf_pkg::CFG_PIXEL_FORMAT:
            reg_format = pngunf_pkg::pixel_format_t'(cfg_data[1:0]);
          pngunf_pkg::CFG_ALPHA_ENABLE: reg_alpha  = cfg_data[0];
          default: ;
        endcase
      end
      if (item_valid && !item_stall) begin
        unfilter_item(item);
        items_taken++;
      end
      if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
          (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  function automatic logic [7:0] random_byte();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_filter(pngunf_pkg::pixel_format_t f);
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
    if (f == pngunf_pkg::FMT_PALETTE4)
      return ($urandom_range(0, 7) == 0) ? 8'($urandom_range(1, 4)) :
                                           8'(pngunf_pkg::FILT_NONE);
    return 8'($urandom_range(0, 4));
  endfunction

  function automatic int burst_chance();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 5;
      2:       return 15;
      default: return 40;
    endcase
  endfunction

  task automatic queue_data(logic [7:0] db);
    pngunf_pkg::item_t it;
    it.cmd           = 1'b0;
    it.data_byte     = db;
    it.palette_index = 8'($urandom);
    it.palette_rgb   = 24'($urandom);
    it.palette_alpha = 8'($urandom);
    pending_items.push_back(it);
    items_queued++;
  endtask

  task automatic queue_palette(logic [7:0] idx);
    pngunf_pkg::item_t it;
    it.cmd           = 1'b1;
    it.data_byte     = 8'($urandom);
    it.palette_index = idx;
    it.palette_rgb   = 24'($urandom);
    it.palette_alpha = random_byte();
    pending_items.push_back(it);
    items_queued++;
  endtask

  task automatic queue_row(logic [7:0] filt, int len);
    queue_data(filt);
    for (int b = 0; b < len; b++) begin
      if ($urandom_range(0, 39) == 0) queue_palette(8'($urandom));
      queue_data(random_byte());
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (items_taken != items_queued || expected_pixels.size() != 0);
    repeat (DRAIN_PAUSE) @(negedge clk);
  endtask

  task automatic write_reg(pngunf_pkg::cfg_index_t idx, int val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= pngunf_pkg::CFG_DATA_W'(val);
    do @(posedge clk);
    while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_config(int w, int h, pngunf_pkg::pixel_format_t f, logic alpha);
    wait_drained();
    write_reg(pngunf_pkg::CFG_IMAGE_WIDTH, w);
    write_reg(pngunf_pkg::CFG_IMAGE_HEIGHT, h);
    write_reg(pngunf_pkg::CFG_PIXEL_FORMAT, int'(f));
    write_reg(pngunf_pkg::CFG_ALPHA_ENABLE, int'(alpha));
  endtask

  initial begin
    int                        r, w, h, len, images;
    int                        random_items;
    pngunf_pkg::pixel_format_t fmt;
    random_items = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int n = 0; n < 256; n++) queue_palette(8'(n));

    // 1x1 palette image under reset settings
    queue_data(8'(pngunf_pkg::FILT_NONE));
    queue_data(8'hff);

    set_config(2, 6, pngunf_pkg::FMT_PALETTE8, 1'b1);
    queue_data(8'(pngunf_pkg::FILT_NONE));    queue_data(8'h00); queue_data(8'hff);
    queue_data(8'(pngunf_pkg::FILT_SUB));     queue_data(8'hff); queue_data(8'hff);
    queue_data(8'(pngunf_pkg::FILT_UP));      queue_data(8'h01); queue_data(8'h80);
    queue_data(8'(pngunf_pkg::FILT_AVERAGE)); queue_data(8'hff); queue_data(8'h7f);
    queue_data(8'(pngunf_pkg::FILT_PAETH));   queue_data(8'h80); queue_data(8'hff);
    queue_data(8'hff);                        queue_data(8'h12); queue_data(8'h34);

    // odd width drops the last low nibble; any filter but None is refused
    set_config(3, 2, pngunf_pkg::FMT_PALETTE4, 1'b0);
    queue_data(8'(pngunf_pkg::FILT_NONE)); queue_data(8'hab); queue_data(8'hcd);
    queue_data(8'(pngunf_pkg::FILT_SUB));  queue_data(8'h5a); queue_data(8'ha5);

    set_config(0, 0, pngunf_pkg::FMT_RGBA8, 1'b1);
    queue_row(8'(pngunf_pkg::FILT_PAETH), 4);

    // tallest image, then shrink the height so the row counter wraps
    set_config(2, pngunf_pkg::DEF_MAX_HEIGHT, pngunf_pkg::FMT_RGB8, 1'b0);
    for (r = 0; r < 3; r++) queue_row(pick_filter(pngunf_pkg::FMT_RGB8), 6);
    set_config(2, 8191, pngunf_pkg::FMT_RGB8, 1'b0);
    for (r = 0; r < 2; r++) queue_row(pick_filter(pngunf_pkg::FMT_RGB8), 6);
    set_config(2, 3, pngunf_pkg::FMT_RGB8, 1'b0);
    for (r = 0; r < 3; r++) queue_row(pick_filter(pngunf_pkg::FMT_RGB8), 6);

    while (random_items < 540) begin
      fmt = pngunf_pkg::pixel_format_t'($urandom_range(0, 3));
      w   = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
      h   = $urandom_range(1, 4);
      if (random_items >= 430) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        gap_pct   = burst_chance();
        stall_pct = burst_chance();
      end
      set_config(w, h, fmt, 1'($urandom_range(0, 1)));
      len    = row_bytes(fmt, w);
      images = $urandom_range(1, 2);
      for (r = 0; r < h * images; r++) queue_row(pick_filter(fmt), len);
      random_items += h * images * (len + 1);
    end

    wait_drained();
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
